[rtl/core/wavw_pkg.sv]
// Package: types, constants and conversion functions for the WAV PCM16 stream writer.
`timescale 1ns / 1ps
package wavw_pkg;

  localparam int unsigned SAMPLE_W  = 32;
  localparam int unsigned CH_W      = 16;
  localparam int unsigned RATE_W    = 31;
  localparam int unsigned FRAMES_W  = 31;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 31;
  localparam int unsigned POS_W     = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_HZ       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_TOTAL  = 2'd2;

  localparam logic [CH_W-1:0]     CH_RESET     = 16'd1;
  localparam logic [RATE_W-1:0]   RATE_RESET   = 31'd44100;
  localparam logic [FRAMES_W-1:0] FRAMES_RESET = 31'd0;

  localparam logic [30:0] MAX_SAMPLES = 31'h7FFF_FFFF;

  localparam logic [POS_W-1:0] HDR_LEN  = 6'd44;
  localparam logic [POS_W-1:0] LAST_POS = 6'd45;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_LARGE   = 2'd2;

  typedef enum logic [1:0] {
    PH_HDR,
    PH_STREAM,
    PH_DONE,
    PH_ERR
  } phase_t;

  typedef enum logic [1:0] {
    K_HDR,
    K_SMP,
    K_ERR
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] pcm;
    logic        end_f;
    logic [1:0]  status;
  } item_t;

  function automatic logic [15:0] to_pcm16(input logic [31:0] bits);
    logic [31:0] b;
    logic [7:0]  e;
    logic [23:0] m;
    logic [38:0] p;
    logic [24:0] q;
    logic        guard;
    logic        sticky;
    logic [7:0]  kk;
    logic [25:0] sum;
    logic [15:0] r;
    b = bits;
    if (b[30:23] == 8'hFF) b = '0;
    if (b[30:0] > 31'h3F80_0000) b[30:0] = 31'h3F80_0000;
    e = b[30:23];
    m = {1'b1, b[22:0]};
    r = '0;
    p = '0;
    q = '0;
    guard = 1'b0;
    sticky = 1'b0;
    kk = '0;
    sum = '0;
    if (e >= 8'd111) begin
      if (!b[31]) begin
        p = {m, 15'b0} - {15'b0, m};
        if (p[38]) begin
          q = {1'b0, p[38:15]};
          guard = p[14];
          sticky = |p[13:0];
          kk = 8'd135 - e;
        end else begin
          q = {1'b0, p[37:14]};
          guard = p[13];
          sticky = |p[12:0];
          kk = 8'd136 - e;
        end
        if (guard && (sticky || q[0])) q = q + 25'd1;
        sum = {1'b0, q} + (26'd1 << (kk - 8'd1));
        r = 16'(sum >> kk);
      end else begin
        kk = 8'd135 - e;
        sum = {2'b0, m} + (26'd1 << (kk - 8'd1));
        r = 16'd0 - 16'(sum >> kk);
      end
    end
    return r;
  endfunction

  function automatic logic [7:0] header_byte(
    input logic [POS_W-1:0] pos,
    input logic [CH_W-1:0]  ch,
    input logic [RATE_W-1:0] rate,
    input logic [31:0]      byte_rate,
    input logic [31:0]      data_bytes
  );
    logic [351:0] h;
    h = '0;
    h[31:0]    = 32'h4646_4952;
    h[63:32]   = data_bytes + 32'd36;
    h[95:64]   = 32'h4556_4157;
    h[127:96]  = 32'h2074_6D66;
    h[159:128] = 32'd16;
    h[175:160] = 16'd1;
    h[191:176] = ch;
    h[223:192] = {1'b0, rate};
    h[255:224] = byte_rate;
    h[271:256] = {ch[14:0], 1'b0};
    h[287:272] = 16'd16;
    h[319:288] = 32'h6174_6164;
    h[351:320] = data_bytes;
    return h[{pos, 3'b000} +: 8];
  endfunction

endpackage

[rtl/core/wavw_if.sv]
// Interfaces: sample input channel and byte result channel.
`timescale 1ns / 1ps
interface wavw_in_if;
  logic                            valid;
  logic                            ready;
  logic [wavw_pkg::SAMPLE_W-1:0]   sample_bits;
  modport source (output valid, output sample_bits, input ready);
  modport sink (input valid, input sample_bits, output ready);
endinterface

interface wavw_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       file_end;
  logic [1:0] status;
  modport source (output valid, output out_byte, output run_last, output file_end,
                  output status, input ready);
  modport sink (input valid, input out_byte, input run_last, input file_end,
                input status, output ready);
endinterface

[rtl/core/wav_pcm16_stream_writer.sv]
// Top level: RIFF/WAVE PCM16 byte stream writer from single-precision samples.
`timescale 1ns / 1ps
// One sample transaction yields two bytes; the first also yields the 44-byte header
// (46 bytes), and an invalid or oversized configuration yields one error byte. The
// one-byte output port paces the stream: the next sample is taken in the cycle the
// previous one's last byte leaves. Header fields and the sample limit come from the
// registers channel_count, rate_hz and frames_total.
module wav_pcm16_stream_writer (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [wavw_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  logic [wavw_pkg::CFG_DAT_W-1:0]       cfg_wdata,
  wavw_in_if.sink                              in_if,
  wavw_out_if.source                           out_if
);

  logic [wavw_pkg::CH_W-1:0]     ch_r;
  logic [wavw_pkg::RATE_W-1:0]   rate_r;
  logic [wavw_pkg::FRAMES_W-1:0] frames_r;
  logic [31:0]                   byte_rate_r;
  logic [31:0]                   data_r;

  wavw_pkg::phase_t phase_r, phase_nxt;
  logic [30:0]      done_r, done_nxt;
  logic             hv_r, hv_nxt;
  logic [wavw_pkg::POS_W-1:0] idx_r, idx_nxt;
  wavw_pkg::item_t  item_r, item_nxt;

  logic [46:0] prod;
  logic [30:0] limit;
  logic        last;
  logic        accept;
  logic [30:0] done_inc;

  assign prod  = 47'(ch_r) * 47'(frames_r);
  assign limit = (prod > 47'(wavw_pkg::MAX_SAMPLES)) ? wavw_pkg::MAX_SAMPLES : prod[30:0];
  assign done_inc = done_r + 31'd1;

  assign last = (item_r.kind == wavw_pkg::K_ERR) || (idx_r == wavw_pkg::LAST_POS);
  assign in_if.ready = !hv_r || (out_if.ready && last);
  assign accept = in_if.valid && in_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_r     <= wavw_pkg::CH_RESET;
      rate_r   <= wavw_pkg::RATE_RESET;
      frames_r <= wavw_pkg::FRAMES_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        wavw_pkg::CFG_CHANNEL_COUNT: ch_r     <= cfg_wdata[wavw_pkg::CH_W-1:0];
        wavw_pkg::CFG_RATE_HZ:       rate_r   <= cfg_wdata[wavw_pkg::RATE_W-1:0];
        wavw_pkg::CFG_FRAMES_TOTAL:  frames_r <= cfg_wdata[wavw_pkg::FRAMES_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    byte_rate_r <= 32'(48'(rate_r) * 48'({ch_r[14:0], 1'b0}));
    data_r      <= 32'({prod, 1'b0});
  end

  always_comb begin
    phase_nxt = phase_r;
    done_nxt  = done_r;
    hv_nxt    = hv_r;
    idx_nxt   = idx_r;
    item_nxt  = item_r;
    if (hv_r && out_if.ready) begin
      if (last) hv_nxt = 1'b0;
      else idx_nxt = idx_r + 6'd1;
    end
    if (accept) begin
      item_nxt.pcm    = wavw_pkg::to_pcm16(in_if.sample_bits);
      item_nxt.status = wavw_pkg::ST_OK;
      item_nxt.end_f  = (done_inc == limit);
      unique case (phase_r)
        wavw_pkg::PH_HDR: begin
          hv_nxt = 1'b1;
          if (ch_r == '0 || rate_r == '0 || frames_r == '0) begin
            item_nxt.kind   = wavw_pkg::K_ERR;
            item_nxt.status = wavw_pkg::ST_INVALID;
            item_nxt.end_f  = 1'b1;
            phase_nxt       = wavw_pkg::PH_ERR;
          end else if (prod > 47'(wavw_pkg::MAX_SAMPLES)) begin
            item_nxt.kind   = wavw_pkg::K_ERR;
            item_nxt.status = wavw_pkg::ST_LARGE;
            item_nxt.end_f  = 1'b1;
            phase_nxt       = wavw_pkg::PH_ERR;
          end else begin
            item_nxt.kind  = wavw_pkg::K_HDR;
            item_nxt.end_f = (limit == 31'd1);
            idx_nxt        = '0;
            done_nxt       = 31'd1;
            phase_nxt      = (limit == 31'd1) ? wavw_pkg::PH_DONE : wavw_pkg::PH_STREAM;
          end
        end
        wavw_pkg::PH_STREAM: begin
          if (done_r >= limit) begin
            phase_nxt = wavw_pkg::PH_DONE;
          end else begin
            hv_nxt        = 1'b1;
            item_nxt.kind = wavw_pkg::K_SMP;
            idx_nxt       = wavw_pkg::HDR_LEN;
            done_nxt      = done_inc;
            if (done_inc == limit) phase_nxt = wavw_pkg::PH_DONE;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= wavw_pkg::PH_HDR;
      done_r  <= '0;
      hv_r    <= 1'b0;
      idx_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      done_r  <= done_nxt;
      hv_r    <= hv_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  always_comb begin
    if (item_r.kind == wavw_pkg::K_ERR) begin
      out_if.out_byte = 8'd0;
    end else if (idx_r < wavw_pkg::HDR_LEN) begin
      out_if.out_byte = wavw_pkg::header_byte(idx_r, ch_r, rate_r, byte_rate_r, data_r);
    end else if (idx_r == wavw_pkg::HDR_LEN) begin
      out_if.out_byte = item_r.pcm[7:0];
    end else begin
      out_if.out_byte = item_r.pcm[15:8];
    end
  end

  assign out_if.valid    = hv_r;
  assign out_if.run_last = last;
  assign out_if.file_end = last && item_r.end_f;
  assign out_if.status   = item_r.status;

  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == wavw_pkg::PH_ERR |=> phase_r == wavw_pkg::PH_ERR)
    else $error("error phase left before reset");

  a_smp_pos: assert property (@(posedge clk) disable iff (!rst_n)
    hv_r && item_r.kind == wavw_pkg::K_SMP |-> idx_r >= wavw_pkg::HDR_LEN)
    else $error("sample transaction points into header");

  a_done_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (phase_r == wavw_pkg::PH_DONE || phase_r == wavw_pkg::PH_ERR) |=> !hv_r)
    else $error("result after file end");

  a_status_err: assert property (@(posedge clk) disable iff (!rst_n)
    hv_r && out_if.status != wavw_pkg::ST_OK |-> out_if.run_last && out_if.file_end)
    else $error("error result not final");

endmodule

[tb/tb_wav_pcm16_stream_writer.sv]
// Testbench: WAV PCM16 stream writer checked byte by byte against a scoreboard.
`timescale 1ns / 1ps
module tb_wav_pcm16_stream_writer;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 60;

  class pcm_file_scoreboard;
    typedef struct {
      logic [7:0] data;
      logic       last;
      logic       fend;
      logic [1:0] st;
    } wav_byte_t;

    wav_byte_t         byte_q[$];
    logic [15:0]       ch;
    logic [30:0]       rate;
    logic [30:0]       frames;
    logic [30:0]       done;
    wavw_pkg::phase_t  ph;
    int                fails;

    function new();
      ch = wavw_pkg::CH_RESET;
      rate = wavw_pkg::RATE_RESET;
      frames = wavw_pkg::FRAMES_RESET;
      done = '0;
      ph = wavw_pkg::PH_HDR;
      fails = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [30:0] v);
      if (idx == wavw_pkg::CFG_CHANNEL_COUNT) ch = v[15:0];
      else if (idx == wavw_pkg::CFG_RATE_HZ) rate = v;
      else if (idx == wavw_pkg::CFG_FRAMES_TOTAL) frames = v;
    endfunction

    function void push(logic [7:0] d, logic last, logic fend, logic [1:0] st);
      wav_byte_t w;
      w.data = d;
      w.last = last;
      w.fend = fend;
      w.st = st;
      byte_q.push_back(w);
    endfunction

    function automatic logic [15:0] pcm16(logic [31:0] bits);
      logic [31:0] v;
      logic [63:0] m, ex, q, rem, half, n;
      int e, sh, k;
      v = bits;
      if (v[30:23] == 8'hFF) v = '0;
      if (v[30:0] > 31'h3F80_0000) v[30:0] = 31'h3F80_0000;
      e = v[30:23];
      if (e == 0) return 16'd0;
      m = {40'd0, 1'b1, v[22:0]};
      if (v[31]) begin
        k = 135 - e;
        if (k > 62) return 16'd0;
        n = (m + (64'd1 << (k - 1))) >> k;
        return 16'(64'd0 - n);
      end
      ex = m * 64'd32767;
      sh = ex[38] ? 15 : 14;
      q = ex >> sh;
      rem = ex & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 1);
      if (rem > half || (rem == half && q[0])) q = q + 64'd1;
      k = 150 - e - sh;
      if (k > 62) return 16'd0;
      n = (q + (64'd1 << (k - 1))) >> k;
      return n[15:0];
    endfunction

    function void note_sample(logic [31:0] bits);
      logic [63:0] prod;
      logic [31:0] lim, data_bytes, byte_rate;
      logic [15:0] align, pcm;
      logic [31:0] w[11];
      logic [1:0]  st;
      logic        fend;
      if (ph == wavw_pkg::PH_DONE || ph == wavw_pkg::PH_ERR) return;
      prod = {48'd0, ch} * {33'd0, frames};
      if (ph == wavw_pkg::PH_HDR) begin
        st = wavw_pkg::ST_OK;
        if (ch == 0 || rate == 0 || frames == 0) st = wavw_pkg::ST_INVALID;
        else if (prod > {33'd0, wavw_pkg::MAX_SAMPLES}) st = wavw_pkg::ST_LARGE;
        if (st != wavw_pkg::ST_OK) begin
          push(8'd0, 1'b1, 1'b1, st);
          ph = wavw_pkg::PH_ERR;
          return;
        end
        data_bytes = prod[31:0] * 32'd2;
        align = {ch[14:0], 1'b0};
        byte_rate = 32'({1'b0, rate} * {16'd0, align});
        w = '{TAG_RIFF, data_bytes + 32'd36, TAG_WAVE, TAG_FMT, 32'd16,
              {ch, 16'd1}, {1'b0, rate}, byte_rate, {16'd16, align}, TAG_DATA,
              data_bytes};
        for (int i = 0; i < 44; i++)
          push(8'(w[i / 4] >> (8 * (i % 4))), 1'b0, 1'b0, wavw_pkg::ST_OK);
        done = '0;
        ph = wavw_pkg::PH_STREAM;
      end
      lim = (prod > {33'd0, wavw_pkg::MAX_SAMPLES}) ? {1'b0, wavw_pkg::MAX_SAMPLES}
                                                    : prod[31:0];
      if ({1'b0, done} >= lim) begin
        ph = wavw_pkg::PH_DONE;
        return;
      end
      pcm = pcm16(bits);
      done = done + 31'd1;
      fend = ({1'b0, done} == lim);
      push(pcm[7:0], 1'b0, 1'b0, wavw_pkg::ST_OK);
      push(pcm[15:8], 1'b1, fend, wavw_pkg::ST_OK);
      if (fend) ph = wavw_pkg::PH_DONE;
    endfunction

    function void check_result(logic [7:0] d, logic last, logic fend, logic [1:0] st);
      wav_byte_t w;
      if (byte_q.size() == 0) begin
        $error("unexpected result byte %0h", d);
        fails++;
        return;
      end
      w = byte_q.pop_front();
      if (d !== w.data) begin
        $error("out_byte expected %0h actual %0h", w.data, d);
        fails++;
      end
      if (last !== w.last) begin
        $error("run_last expected %0b actual %0b", w.last, last);
        fails++;
      end
      if (fend !== w.fend) begin
        $error("file_end expected %0b actual %0b", w.fend, fend);
        fails++;
      end
      if (st !== w.st) begin
        $error("status expected %0d actual %0d", w.st, st);
        fails++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [wavw_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
  logic [wavw_pkg::CFG_DAT_W-1:0] cfg_wdata = '0;
  int idle_in = 32;
  int idle_out = 64;
  int cycles = 0;
  pcm_file_scoreboard sb = new();

  wavw_in_if in_if();
  wavw_out_if out_if();

  wav_pcm16_stream_writer dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
    .cfg_wdata(cfg_wdata), .in_if(in_if.sink), .out_if(out_if.source)
  );

  always #6 clk = ~clk;

  initial begin
    in_if.valid = 1'b0;
    in_if.sample_bits = '0;
    out_if.ready = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(negedge clk) out_if.ready <= ($urandom_range(99) >= idle_out);

  always @(posedge clk)
    if (rst_n && out_if.valid && out_if.ready)
      sb.check_result(out_if.out_byte, out_if.run_last, out_if.file_end, out_if.status);

  task automatic send_sample(logic [31:0] bits);
    while ($urandom_range(99) < idle_in) begin
      in_if.valid = 1'b0;
      @(negedge clk);
    end
    in_if.valid = 1'b1;
    in_if.sample_bits = bits;
    do @(posedge clk); while (!in_if.ready);
    sb.note_sample(bits);
    @(negedge clk);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [30:0] v);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_wdata = v;
    sb.write_reg(idx, v);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic settle();
    in_if.valid = 1'b0;
    while (sb.byte_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [31:0] rand_sample();
    if ($urandom_range(3) == 0) return $urandom;
    return {1'($urandom), 8'($urandom_range(127, 100)), 23'($urandom)};
  endfunction

  logic [31:0] directed[] = '{
    32'h0000_0000, 32'h8000_0000, 32'h3F80_0000, 32'hBF80_0000, 32'h7F80_0000,
    32'hFF80_0000, 32'h7FC0_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0001,
    32'h3F00_0000, 32'hBF00_0000, 32'h3780_0000, 32'hB780_0000, 32'h4000_0000,
    32'hC000_0000, 32'h7F7F_FFFF, 32'h3F7F_FFFF, 32'hBF7F_FFFF, 32'h3EFF_FFFF,
    32'h007F_FFFF
  };

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    write_cfg(wavw_pkg::CFG_CHANNEL_COUNT, 31'd2);
    write_cfg(wavw_pkg::CFG_RATE_HZ, 31'h7FFF_FFFF);
    write_cfg(wavw_pkg::CFG_FRAMES_TOTAL, 31'd300);
    foreach (directed[i]) send_sample(directed[i]);
    repeat (130) send_sample(rand_sample());
    settle();
    write_cfg(wavw_pkg::CFG_CHANNEL_COUNT, 31'hFFFF);
    write_cfg(wavw_pkg::CFG_FRAMES_TOTAL, 31'h7FFF_FFFF);
    write_cfg(wavw_pkg::CFG_RATE_HZ, 31'd1);
    idle_in = 64;
    idle_out = 32;
    repeat (140) send_sample(rand_sample());
    settle();
    write_cfg(wavw_pkg::CFG_CHANNEL_COUNT, 31'd1);
    idle_in = 0;
    idle_out = 0;
    repeat (130) send_sample(rand_sample());
    settle();
    write_cfg(wavw_pkg::CFG_FRAMES_TOTAL, sb.done + 31'd4);
    repeat (8) send_sample(rand_sample());
    settle();
    write_cfg(wavw_pkg::CFG_FRAMES_TOTAL, 31'd0);
    write_cfg(wavw_pkg::CFG_CHANNEL_COUNT, 31'd0);
    repeat (2) send_sample(rand_sample());
    settle();
    if (sb.fails == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
